// ===== hw/rtl/ptb_pkg.sv =====
// shared types, codes and defaults of the pausable timer bank
package ptb_pkg;

   localparam int NUM_TIMERS_DEF = 8;

   localparam int FUNC_W  = 3;
   localparam int INDEX_W = 3;
   localparam int COUNT_W = 16;
   localparam int STATE_W = 2;

   // operation codes
   localparam logic [FUNC_W-1:0] OP_TICK    = 3'd0;
   localparam logic [FUNC_W-1:0] OP_START   = 3'd1;
   localparam logic [FUNC_W-1:0] OP_STOP    = 3'd2;
   localparam logic [FUNC_W-1:0] OP_PAUSE   = 3'd3;
   localparam logic [FUNC_W-1:0] OP_RELEASE = 3'd4;
   localparam logic [FUNC_W-1:0] OP_READ    = 3'd5;

   // timer run states
   localparam logic [STATE_W-1:0] RS_STOPPED = 2'd0;
   localparam logic [STATE_W-1:0] RS_RUNNING = 2'd1;
   localparam logic [STATE_W-1:0] RS_PAUSED  = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [INDEX_W-1:0] timer_index;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count_value;
      logic [STATE_W-1:0] run_state;
   } rsp_type;

   typedef struct packed {
      logic [STATE_W-1:0] run_state;
      logic [COUNT_W-1:0] count;
   } entry_type;

endpackage

// ===== hw/rtl/ptb_entry_store.sv =====
// timer entry memory with per-entry valid bits; an unwritten entry reads as zero
module ptb_entry_store #(
   parameter int DEPTH = ptb_pkg::NUM_TIMERS_DEF,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output ptb_pkg::entry_type  rd_data,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  ptb_pkg::entry_type  wr_data
);

   ptb_pkg::entry_type mem [DEPTH];
   logic [DEPTH-1:0]   vld_ff;
   logic [DEPTH-1:0]   vld_in;
   ptb_pkg::entry_type rd_raw_ff;
   logic               rd_vld_ff;

   always_comb begin
      vld_in = vld_ff;
      if (wr_en) begin
         vld_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_raw_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_vld_ff ? rd_raw_ff : '0;

endmodule

// ===== hw/rtl/pausable_timer_bank.sv =====
// bank of pausable 16-bit timers driven by a small sequencer over one entry memory
//
//  channel  dir  ports                           transaction
//  req      in   req_valid req_stall req_data    func, timer_index
//  rsp      out  rsp_valid rsp_stall rsp_data    count_value, run_state
//
// tick sweeps one incrementer over the memory, one timer per cycle, reading
// each timer while the one before is written back; other operations read
// the memory, update the entry and load the result, and an index beyond
// the bank skips the memory and answers zero.
// reset clears the valid bits at once, so all timers read stopped with count 0.
// req_stall is high from accept until the result is loaded into the output
// register; a stalled result holds the block in its final state.
module pausable_timer_bank #(
   parameter int NUM_TIMERS = ptb_pkg::NUM_TIMERS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ptb_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ptb_pkg::rsp_type rsp_data
);

   localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CW = $clog2(NUM_TIMERS + 1);
   localparam int XW = (AW > ptb_pkg::INDEX_W) ? AW : ptb_pkg::INDEX_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_SWEEP = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_LOOK  = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]                  state_ff, state_in;
   logic [ptb_pkg::FUNC_W-1:0]  op_ff, op_in;
   logic [AW-1:0]               idx_ff, idx_in;
   logic [CW-1:0]               sweep_cnt_ff, sweep_cnt_in;
   logic                        rd_pend_ff, rd_pend_in;
   logic [AW-1:0]               wr_addr_ff, wr_addr_in;
   ptb_pkg::rsp_type            res_ff, res_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   ptb_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic                        req_take;
   logic [XW-1:0]               idx_ext;
   logic                        idx_ok;
   logic                        rd_en;
   logic [AW-1:0]               rd_addr;
   ptb_pkg::entry_type          rd_data;
   logic                        wr_en;
   logic [AW-1:0]               wr_addr;
   ptb_pkg::entry_type          wr_data;
   ptb_pkg::entry_type          upd;
   logic                        out_free;

   ptb_entry_store #(
      .DEPTH (NUM_TIMERS),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign idx_ext   = XW'(req_data.timer_index);
   assign idx_ok    = (32'(req_data.timer_index) < NUM_TIMERS);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // single-timer update from the entry read out of memory
   always_comb begin
      upd = rd_data;
      case (op_ff)
         ptb_pkg::OP_START: begin
            if (rd_data.run_state == ptb_pkg::RS_STOPPED) begin
               upd.count     = '0;
               upd.run_state = ptb_pkg::RS_RUNNING;
            end
         end
         ptb_pkg::OP_STOP: begin
            upd.run_state = ptb_pkg::RS_STOPPED;
         end
         ptb_pkg::OP_PAUSE: begin
            if (rd_data.run_state == ptb_pkg::RS_RUNNING) begin
               upd.run_state = ptb_pkg::RS_PAUSED;
            end
         end
         ptb_pkg::OP_RELEASE: begin
            if (rd_data.run_state == ptb_pkg::RS_PAUSED) begin
               upd.run_state = ptb_pkg::RS_RUNNING;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      sweep_cnt_in = sweep_cnt_ff;
      rd_pend_in   = 1'b0;
      wr_addr_in   = wr_addr_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rd_en        = 1'b0;
      rd_addr      = idx_ff;
      wr_en        = 1'b0;
      wr_addr      = wr_addr_ff;
      wr_data      = upd;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               op_in        = req_data.func;
               idx_in       = idx_ext[AW-1:0];
               sweep_cnt_in = '0;
               res_in       = '0;
               if (req_data.func == ptb_pkg::OP_TICK) begin
                  state_in = ST_SWEEP;
               end else if (idx_ok) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SWEEP: begin
            // read timer n while timer n-1 is written back
            if (rd_pend_ff && (rd_data.run_state == ptb_pkg::RS_RUNNING)) begin
               wr_en         = 1'b1;
               wr_data.count = rd_data.count + 1'b1;
            end
            if (32'(sweep_cnt_ff) < NUM_TIMERS) begin
               rd_en        = 1'b1;
               rd_addr      = sweep_cnt_ff[AW-1:0];
               rd_pend_in   = 1'b1;
               wr_addr_in   = sweep_cnt_ff[AW-1:0];
               sweep_cnt_in = sweep_cnt_ff + 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_READ: begin
            rd_en      = 1'b1;
            rd_addr    = idx_ff;
            wr_addr_in = idx_ff;
            state_in   = ST_LOOK;
         end
         ST_LOOK: begin
            wr_en              = 1'b1;
            wr_data            = upd;
            res_in.count_value = upd.count;
            res_in.run_state   = upd.run_state;
            state_in           = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sweep_cnt_ff <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_cnt_ff <= sweep_cnt_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      idx_ff      <= idx_in;
      wr_addr_ff  <= wr_addr_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_no_write_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !wr_en)
      else $error("memory write while idle");

   a_sweep_bound: assert property (@(posedge clock) disable iff (reset)
      32'(sweep_cnt_ff) <= NUM_TIMERS)
      else $error("sweep counter past bank");

   a_pend_in_sweep: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> (state_ff == ST_SWEEP))
      else $error("pending sweep read outside sweep");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_stall)
      else $error("not busy after accepting a transaction");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> (rsp_valid && state_ff == ST_IDLE))
      else $error("result not loaded on completion");

endmodule

// ===== test/pausable_timer_bank_tb.sv =====
// self-checking testbench for the pausable timer bank: directed, random and pause-hold traffic
module pausable_timer_bank_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_TIMERS     = ptb_pkg::NUM_TIMERS_DEF;
   localparam int RESET_CYCLES   = 12;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = NUM_TIMERS + 12;
   localparam int MAX_PRINTED    = 40;
   localparam int RANDOM_ITEMS   = 120;
   localparam int HOLD_TICKS     = 30;
   localparam int IDX_W          = ptb_pkg::INDEX_W;
   localparam int INDEX_MAX      = (1 << IDX_W) - 1;

   // func codes the block does not define, answered like a read
   localparam logic [ptb_pkg::FUNC_W-1:0] OP_SPARE6 = 3'd6;
   localparam logic [ptb_pkg::FUNC_W-1:0] OP_SPARE7 = 3'd7;

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   ptb_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   ptb_pkg::rsp_type rsp_data;

   // local copy of the bank
   logic [ptb_pkg::COUNT_W-1:0] tmr_count [NUM_TIMERS];
   logic [ptb_pkg::STATE_W-1:0] tmr_state [NUM_TIMERS];
   ptb_pkg::rsp_type            timer_rsp_q [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int err_count     = 0;
   int items_sent    = 0;
   int rsps_checked  = 0;
   int quiet_cycles  = 0;

   pausable_timer_bank #(
      .NUM_TIMERS(NUM_TIMERS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   task automatic report_mismatch(string what, int got, int want);
      if (err_count < MAX_PRINTED) begin
         $display("%0t ns mismatch: %s got %0d want %0d", $realtime, what, got, want);
      end
      err_count++;
   endtask

   // applies one operation to the local bank and returns the answer it should give
   function automatic ptb_pkg::rsp_type apply_timer_op(ptb_pkg::req_type op);
      ptb_pkg::rsp_type res;
      int k;
      res = '0;
      k = int'(op.timer_index);
      if (op.func == ptb_pkg::OP_TICK) begin
         for (int t = 0; t < NUM_TIMERS; t++) begin
            if (tmr_state[t] == ptb_pkg::RS_RUNNING) tmr_count[t] = tmr_count[t] + 1'b1;
         end
         return res;
      end
      if (k >= NUM_TIMERS) return res;
      case (op.func)
         ptb_pkg::OP_START: begin
            if (tmr_state[k] == ptb_pkg::RS_STOPPED) begin
               tmr_count[k] = '0;
               tmr_state[k] = ptb_pkg::RS_RUNNING;
            end
         end
         ptb_pkg::OP_STOP: begin
            tmr_state[k] = ptb_pkg::RS_STOPPED;
         end
         ptb_pkg::OP_PAUSE: begin
            if (tmr_state[k] == ptb_pkg::RS_RUNNING) tmr_state[k] = ptb_pkg::RS_PAUSED;
         end
         ptb_pkg::OP_RELEASE: begin
            if (tmr_state[k] == ptb_pkg::RS_PAUSED) tmr_state[k] = ptb_pkg::RS_RUNNING;
         end
         default: ;
      endcase
      res.count_value = tmr_count[k];
      res.run_state   = tmr_state[k];
      return res;
   endfunction

   task automatic send_op(logic [ptb_pkg::FUNC_W-1:0] func, logic [IDX_W-1:0] idx);
      ptb_pkg::req_type item;
      item.func        = func;
      item.timer_index = idx;
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = item;
      do @(posedge clock); while (req_stall);
      timer_rsp_q.push_back(apply_timer_op(item));
      items_sent++;
   endtask

   // hold off the sender until every outstanding result is back
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (timer_rsp_q.size() != 0) @(negedge clock);
   endtask

   always @(posedge clock) begin
      ptb_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (timer_rsp_q.size() == 0) begin
            report_mismatch("result with nothing outstanding, count", rsp_data.count_value, 0);
         end else begin
            want = timer_rsp_q.pop_front();
            if (rsp_data.count_value !== want.count_value) begin
               report_mismatch("count_value", rsp_data.count_value, want.count_value);
            end
            if (rsp_data.run_state !== want.run_state) begin
               report_mismatch("run_state", rsp_data.run_state, want.run_state);
            end
         end
         rsps_checked++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task automatic test_directed();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_op(ptb_pkg::OP_READ, 3'd0);
      send_op(ptb_pkg::OP_TICK, 3'd5);        // index ignored, nothing running yet
      send_op(ptb_pkg::OP_START, 3'd0);
      send_op(ptb_pkg::OP_START, 3'd7);
      send_op(ptb_pkg::OP_TICK, 3'd0);
      send_op(ptb_pkg::OP_TICK, 3'd7);
      send_op(ptb_pkg::OP_START, 3'd0);       // already running, no restart
      send_op(ptb_pkg::OP_PAUSE, 3'd0);
      send_op(ptb_pkg::OP_TICK, 3'd0);
      send_op(ptb_pkg::OP_PAUSE, 3'd0);       // already paused
      send_op(ptb_pkg::OP_RELEASE, 3'd7);     // running, not paused
      send_op(ptb_pkg::OP_RELEASE, 3'd0);
      send_op(ptb_pkg::OP_TICK, 3'd0);
      send_op(ptb_pkg::OP_STOP, 3'd0);        // count kept
      send_op(ptb_pkg::OP_TICK, 3'd0);
      send_op(ptb_pkg::OP_READ, 3'd0);
      send_op(ptb_pkg::OP_PAUSE, 3'd3);       // stopped, not running
      send_op(ptb_pkg::OP_RELEASE, 3'd3);
      send_op(ptb_pkg::OP_STOP, 3'd3);
      send_op(ptb_pkg::OP_START, 3'd0);       // restart from stopped clears the count
      send_op(OP_SPARE6, 3'd7);
      send_op(OP_SPARE7, 3'd0);
      send_op(ptb_pkg::OP_STOP, 3'd7);
      send_op(ptb_pkg::OP_READ, 3'd7);
      wait_drained();
   endtask

   task automatic test_random_traffic(int items, int send_pct, int recv_pct);
      int pick;
      logic [ptb_pkg::FUNC_W-1:0] func;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (items) begin
         pick = $urandom_range(99);
         if (pick < 25)      func = ptb_pkg::OP_TICK;
         else if (pick < 40) func = ptb_pkg::OP_START;
         else if (pick < 50) func = ptb_pkg::OP_STOP;
         else if (pick < 65) func = ptb_pkg::OP_PAUSE;
         else if (pick < 80) func = ptb_pkg::OP_RELEASE;
         else if (pick < 92) func = ptb_pkg::OP_READ;
         else if (pick < 96) func = OP_SPARE6;
         else                func = OP_SPARE7;
         send_op(func, IDX_W'($urandom_range(INDEX_MAX)));
      end
      wait_drained();
   endtask

   // runs one timer through a stretch of ticks while a paused one holds its count
   task automatic test_pause_hold();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_op(ptb_pkg::OP_STOP, 3'd1);
      send_op(ptb_pkg::OP_STOP, 3'd2);
      send_op(ptb_pkg::OP_START, 3'd1);
      send_op(ptb_pkg::OP_START, 3'd2);
      repeat (HOLD_TICKS) send_op(ptb_pkg::OP_TICK, 3'd0);
      send_op(ptb_pkg::OP_PAUSE, 3'd2);
      repeat (HOLD_TICKS) send_op(ptb_pkg::OP_TICK, 3'd0);
      send_op(ptb_pkg::OP_READ, 3'd1);
      send_op(ptb_pkg::OP_TICK, 3'd0);
      send_op(ptb_pkg::OP_READ, 3'd1);
      send_op(ptb_pkg::OP_TICK, 3'd0);
      send_op(ptb_pkg::OP_READ, 3'd1);
      send_op(ptb_pkg::OP_READ, 3'd2);
      send_op(ptb_pkg::OP_RELEASE, 3'd2);
      send_op(ptb_pkg::OP_STOP, 3'd1);
      wait_drained();
   endtask

   initial begin
      for (int k = 0; k < NUM_TIMERS; k++) begin
         tmr_count[k] = '0;
         tmr_state[k] = ptb_pkg::RS_STOPPED;
      end
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random_traffic(RANDOM_ITEMS, 29, 46);
      test_random_traffic(RANDOM_ITEMS, 46, 29);
      test_random_traffic(RANDOM_ITEMS, 0, 0);
      test_pause_hold();

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (timer_rsp_q.size() != 0) begin
         report_mismatch("results never returned", timer_rsp_q.size(), 0);
      end
      $display("covered %0d transactions and %0d results: every func code, all indexes,",
               items_sent, rsps_checked);
      $display("three idle mixes and a paused timer held across ticks; %0d mismatches",
               err_count);
      if (err_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/ptb_pkg.sv
hw/rtl/ptb_entry_store.sv
hw/rtl/pausable_timer_bank.sv
test/pausable_timer_bank_tb.sv
